// ----- src/dalitz_cubic_polynomial_pdf_core_macros.svh -----
// Assertion macros shared by the core files.
`ifndef DALITZ_CUBIC_POLYNOMIAL_PDF_CORE_MACROS_SVH
`define DALITZ_CUBIC_POLYNOMIAL_PDF_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DCP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dcp_pkg.sv -----
// Types, constants and register codes for the Dalitz polynomial density core.
package dcp_pkg;

    localparam int MASS_FRACTION_BITS = 30;
    localparam int MASS_W             = 32;
    localparam int UW                 = MASS_W + 30 - MASS_FRACTION_BITS;
    localparam int SQ_STEPS           = 32;
    localparam int DIV_STEPS          = 32;
    localparam int CFG_IDX_W          = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CROSS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUBE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M12SQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_FLR  = 3'd5;

    // Q30 constants, rounded half up: floor((2*N*2^30 + D) / (2*D))
    localparam logic [127:0] MSQ_X =
        (((128'd18645 * 128'd18645) << 31) + 128'd100000000) / 128'd200000000;
    localparam logic [127:0] M1SQ_X =
        (((128'd493677 * 128'd493677) << 31) + 128'd1000000000000)
        / 128'd2000000000000;
    localparam logic [127:0] M2SQ_X =
        (((128'd13957018 * 128'd13957018) << 31) + 128'd10000000000000000)
        / 128'd20000000000000000;
    localparam logic [127:0] M3SQ_X =
        (((128'd1349766 * 128'd1349766) << 31) + 128'd100000000000000)
        / 128'd200000000000000;
    localparam logic [127:0] M2Q_X =
        ((128'd13957018 << 31) + 128'd100000000) / 128'd200000000;
    localparam logic [127:0] M3Q_X =
        ((128'd1349766 << 31) + 128'd10000000) / 128'd20000000;

    localparam logic [31:0] MSQ    = 32'(MSQ_X);
    localparam logic [31:0] M1SQ   = 32'(M1SQ_X);
    localparam logic [31:0] M2SQ   = 32'(M2SQ_X);
    localparam logic [31:0] M3SQ   = 32'(M3SQ_X);
    localparam logic [31:0] M2Q    = 32'(M2Q_X);
    localparam logic [31:0] M3Q    = 32'(M3Q_X);
    localparam logic [63:0] M2Q_SQ = 64'(M2Q_X * M2Q_X);
    localparam logic [63:0] M3Q_SQ = 64'(M3Q_X * M3Q_X);
    localparam logic [32:0] SUMSQ  = 33'(MSQ_X + M1SQ_X + M2SQ_X + M3SQ_X);

    typedef struct packed {
        logic [MASS_W-1:0] mass12_squared;
        logic [MASS_W-1:0] mass13_squared;
    } dcp_event_t;

    typedef struct packed {
        logic signed [47:0] density_value;
        logic               inside_region;
    } dcp_result_t;

endpackage

// ----- src/dcp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module dcp_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import dcp_pkg::*;

    logic [63:0] x_cur [SQ_STEPS];
    logic [63:0] r_cur [SQ_STEPS];
    logic [63:0] x_reg [SQ_STEPS];
    logic [63:0] r_reg [SQ_STEPS];

    assign x_cur[0] = radicand;
    assign r_cur[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        if (k > 0)
        begin : g_link
            assign x_cur[k] = x_reg[k-1];
            assign r_cur[k] = r_reg[k-1];
        end

        assign trial = r_cur[k] + STEP_BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (x_cur[k] >= trial)
                begin
                    x_reg[k] <= x_cur[k] - trial;
                    r_reg[k] <= (r_cur[k] >> 1) + STEP_BIT;
                end
                else
                begin
                    x_reg[k] <= x_cur[k];
                    r_reg[k] <= r_cur[k] >> 1;
                end
            end
        end
    end

    assign root = r_reg[SQ_STEPS-1][31:0];

endmodule

// ----- src/dcp_div.sv -----
// Pipelined restoring divider: 56-bit dividend, 26-bit divisor, 32-bit quotient.
module dcp_div (
    input  logic        clk,
    input  logic        en,
    input  logic [55:0] num,
    input  logic [25:0] den,
    output logic [31:0] quo
);
    import dcp_pkg::*;

    logic [25:0] rem_cur [DIV_STEPS];
    logic [31:0] low_cur [DIV_STEPS];
    logic [25:0] den_cur [DIV_STEPS];
    logic [25:0] rem_reg [DIV_STEPS];
    logic [31:0] low_reg [DIV_STEPS];
    logic [25:0] den_reg [DIV_STEPS];

    // high part must already be below the divisor for a 32-bit quotient
    assign rem_cur[0] = {2'b00, num[55:32]};
    assign low_cur[0] = num[31:0];
    assign den_cur[0] = den;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [26:0] part;
        logic        ge;

        if (k > 0)
        begin : g_link
            assign rem_cur[k] = rem_reg[k-1];
            assign low_cur[k] = low_reg[k-1];
            assign den_cur[k] = den_reg[k-1];
        end

        assign part = {rem_cur[k], low_cur[k][31]};
        assign ge   = part >= {1'b0, den_cur[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 26'(part - {1'b0, den_cur[k]}) : part[25:0];
                low_reg[k] <= {low_cur[k][30:0], ge};
                den_reg[k] <= den_cur[k];
            end
        end
    end

    assign quo = low_reg[DIV_STEPS-1];

endmodule

// ----- src/dalitz_cubic_polynomial_pdf_core.sv -----
// Dalitz polynomial density core: region test plus cubic polynomial. Takes one event
// per clock while event_stall is low and returns one result per event, in order. With
// the output buffer empty, result_valid rises once the event passes the input register,
// 101 further pipeline stages, then the output buffer. Depth comes from the bit-serial
// units in the region test: a 32-stage square root of m12, two 32-stage dividers for the
// daughter energies and two more 32-stage square roots for the momenta; the polynomial
// runs in the last three stages. A two-entry output buffer lets the pipeline keep
// accepting while one result waits; event_stall rises only once both entries are full.
// Configuration writes are always ready and must be done while idle.
`include "dalitz_cubic_polynomial_pdf_core_macros.svh"

module dalitz_cubic_polynomial_pdf_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             event_valid,
    output logic                             event_stall,
    input  dcp_pkg::dcp_event_t              event_data,
    output logic                             result_valid,
    input  logic                             result_stall,
    output dcp_pkg::dcp_result_t             result_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);
    import dcp_pkg::*;

    localparam logic signed [51:0] SAT_HI = 52'sh7FFF_FFFF_FFFF;
    localparam logic signed [51:0] SAT_LO = -SAT_HI - 52'sd1;
    localparam logic signed [51:0] ONE_Q32 = 52'sd1 <<< 32;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        ok;
        logic [31:0] a;
        logic [31:0] b;
    } side1_t;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        ok;
    } side2_t;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        ok;
        logic [31:0] e2;
        logic [31:0] e3;
    } side3_t;

    function automatic logic signed [45:0] term_q32(input logic [31:0] coef,
                                                   input logic [35:0] mono);
        logic signed [63:0] prod;
        prod = $signed(coef) * $signed({1'b0, mono[35:5]});
        return prod[62:17];
    endfunction

    // ---------------- configuration ----------------
    logic [63:0] coef_lin_reg, coef_sq_reg, coef_cc_reg, coef_cm_reg;
    logic [31:0] coef_uuv_reg;
    logic [46:0] floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_lin_reg <= '0;
            coef_sq_reg  <= '0;
            coef_cc_reg  <= '0;
            coef_cm_reg  <= '0;
            coef_uuv_reg <= '0;
            floor_reg    <= 47'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COEF_LINEAR: coef_lin_reg <= cfg_data;
                CFG_COEF_SQUARE: coef_sq_reg  <= cfg_data;
                CFG_COEF_CROSS:  coef_cc_reg  <= cfg_data;
                CFG_COEF_CUBE:   coef_cm_reg  <= cfg_data;
                CFG_COEF_M12SQ:  coef_uuv_reg <= cfg_data[31:0];
                CFG_OUTSIDE_FLR: floor_reg    <= cfg_data[46:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [1:0]  cnt_reg;
    logic        en, push, pop;
    dcp_result_t res_h;
    dcp_result_t buf0_reg, buf1_reg;
    logic        vld_g_reg;

    assign en          = (cnt_reg != 2'd2);
    assign event_stall = !en;
    assign push        = en && vld_g_reg;
    assign pop         = (cnt_reg != 2'd0) && !result_stall;

    // ---------------- stage A: offsets and early rejects ----------------
    logic [UW-1:0]          u_full, v_full;
    logic signed [UW+1:0]   a_full, b_full;
    logic                   ok_a;
    logic                   vld_a_reg, ok_a_reg;
    logic [31:0]            u_a_reg, v_a_reg, a_a_reg, b_a_reg;

    assign u_full = UW'(event_data.mass12_squared) << (30 - MASS_FRACTION_BITS);
    assign v_full = UW'(event_data.mass13_squared) << (30 - MASS_FRACTION_BITS);
    assign a_full = $signed({2'b00, u_full}) - $signed((UW+2)'(M1SQ))
                    + $signed((UW+2)'(M2SQ));
    assign b_full = $signed((UW+2)'(MSQ)) - $signed({2'b00, u_full})
                    - $signed((UW+2)'(M3SQ));
    // m13 at or above 2^32 always lies above the upper limit
    assign ok_a = (u_full != '0) && (a_full > 0) && (b_full > 0)
                  && ({1'b0, v_full} < (UW+1)'(64'h1_0000_0000));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else if (en)
            vld_a_reg <= event_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_a_reg  <= u_full[31:0];
            v_a_reg  <= v_full[31:0];
            a_a_reg  <= a_full[31:0];
            b_a_reg  <= b_full[31:0];
            ok_a_reg <= ok_a;
        end
    end

    // ---------------- sqrt(m12) in Q25 ----------------
    logic [31:0]         rs_root;
    logic [SQ_STEPS-1:0] s1_vld_reg;
    side1_t              s1_reg [SQ_STEPS];

    dcp_sqrt u_sqrt_m12 (
        .clk      (clk),
        .en       (en),
        .radicand ({12'd0, u_a_reg, 20'd0}),
        .root     (rs_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= '0;
        else if (en)
            s1_vld_reg <= {s1_vld_reg[SQ_STEPS-2:0], vld_a_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg[0] <= '{u: u_a_reg, v: v_a_reg, ok: ok_a_reg, a: a_a_reg, b: b_a_reg};
            for (int i = 1; i < SQ_STEPS; i++)
                s1_reg[i] <= s1_reg[i-1];
        end
    end

    // ---------------- energies e2, e3 ----------------
    logic [31:0]          e2_q, e3_q;
    logic [DIV_STEPS-1:0] s2_vld_reg;
    side2_t               s2_reg [DIV_STEPS];
    side1_t               s1_end;

    assign s1_end = s1_reg[SQ_STEPS-1];

    dcp_div u_div_e2 (
        .clk (clk),
        .en  (en),
        .num ({s1_end.a, 24'd0}),
        .den (rs_root[25:0]),
        .quo (e2_q)
    );

    dcp_div u_div_e3 (
        .clk (clk),
        .en  (en),
        .num ({s1_end.b, 24'd0}),
        .den (rs_root[25:0]),
        .quo (e3_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= '0;
        else if (en)
            s2_vld_reg <= {s2_vld_reg[DIV_STEPS-2:0], s1_vld_reg[SQ_STEPS-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg[0] <= '{u: s1_end.u, v: s1_end.v, ok: s1_end.ok};
            for (int i = 1; i < DIV_STEPS; i++)
                s2_reg[i] <= s2_reg[i-1];
        end
    end

    // ---------------- stage C: energy squares, stage D: momentum radicands ----------
    side2_t      s2_end;
    logic        vld_c_reg, ok_c_reg, vld_d_reg, ok_d_reg;
    logic [31:0] u_c_reg, v_c_reg, e2_c_reg, e3_c_reg;
    logic [63:0] esq2_c_reg, esq3_c_reg;
    logic [31:0] u_d_reg, v_d_reg, e2_d_reg, e3_d_reg;
    logic [63:0] rad2_d_reg, rad3_d_reg;

    assign s2_end = s2_reg[DIV_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_c_reg <= s2_vld_reg[DIV_STEPS-1];
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_c_reg    <= s2_end.u;
            v_c_reg    <= s2_end.v;
            e2_c_reg   <= e2_q;
            e3_c_reg   <= e3_q;
            // energy equal to the daughter mass still passes
            ok_c_reg   <= s2_end.ok && (e2_q >= M2Q) && (e3_q >= M3Q);
            esq2_c_reg <= 64'(e2_q) * 64'(e2_q);
            esq3_c_reg <= 64'(e3_q) * 64'(e3_q);

            u_d_reg    <= u_c_reg;
            v_d_reg    <= v_c_reg;
            e2_d_reg   <= e2_c_reg;
            e3_d_reg   <= e3_c_reg;
            ok_d_reg   <= ok_c_reg;
            rad2_d_reg <= esq2_c_reg - M2Q_SQ;
            rad3_d_reg <= esq3_c_reg - M3Q_SQ;
        end
    end

    // ---------------- momenta p2, p3 ----------------
    logic [31:0]         p2_root, p3_root;
    logic [SQ_STEPS-1:0] s3_vld_reg;
    side3_t              s3_reg [SQ_STEPS];
    side3_t              s3_end;

    dcp_sqrt u_sqrt_p2 (
        .clk      (clk),
        .en       (en),
        .radicand (rad2_d_reg),
        .root     (p2_root)
    );

    dcp_sqrt u_sqrt_p3 (
        .clk      (clk),
        .en       (en),
        .radicand (rad3_d_reg),
        .root     (p3_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= '0;
        else if (en)
            s3_vld_reg <= {s3_vld_reg[SQ_STEPS-2:0], vld_d_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg[0] <= '{u: u_d_reg, v: v_d_reg, ok: ok_d_reg,
                           e2: e2_d_reg, e3: e3_d_reg};
            for (int i = 1; i < SQ_STEPS; i++)
                s3_reg[i] <= s3_reg[i-1];
        end
    end

    assign s3_end = s3_reg[SQ_STEPS-1];

    // ---------------- stage E: sums, second-order monomials ----------------
    logic        vld_e_reg, ok_e_reg;
    logic [31:0] u_e_reg, v_e_reg;
    logic [32:0] x_e_reg, s_e_reg, d_e_reg;
    logic [33:0] uu_e_reg, vv_e_reg, uv_e_reg;
    logic [63:0] uu_p, vv_p, uv_p;

    assign uu_p = 64'(s3_end.u) * 64'(s3_end.u);
    assign vv_p = 64'(s3_end.v) * 64'(s3_end.v);
    assign uv_p = 64'(s3_end.u) * 64'(s3_end.v);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_e_reg  <= s3_end.u;
            v_e_reg  <= s3_end.v;
            ok_e_reg <= s3_end.ok;
            x_e_reg  <= 33'(s3_end.e2) + 33'(s3_end.e3);
            s_e_reg  <= 33'(p2_root) + 33'(p3_root);
            d_e_reg  <= (p2_root >= p3_root) ? 33'(p2_root - p3_root)
                                             : 33'(p3_root - p2_root);
            uu_e_reg <= uu_p[63:30];
            vv_e_reg <= vv_p[63:30];
            uv_e_reg <= uv_p[63:30];
        end
    end

    // ---------------- stage F: squared sums, cubes, low-order terms ----------------
    logic               vld_f_reg, ok_f_reg;
    logic [31:0]        u_f_reg, v_f_reg;
    logic [35:0]        x2_f_reg, s2_f_reg, d2_f_reg;
    logic [35:0]        uuu_f_reg, vvv_f_reg, uvv_f_reg, uuv_f_reg;
    logic signed [45:0] t1_f_reg, t2_f_reg, t3_f_reg, t4_f_reg, t5_f_reg;
    logic [65:0]        x2_p, s2_p, d2_p, uuu_p, vvv_p, uvv_p, uuv_p;

    assign x2_p  = 66'(x_e_reg) * 66'(x_e_reg);
    assign s2_p  = 66'(s_e_reg) * 66'(s_e_reg);
    assign d2_p  = 66'(d_e_reg) * 66'(d_e_reg);
    assign uuu_p = 66'(uu_e_reg) * 66'(u_e_reg);
    assign vvv_p = 66'(vv_e_reg) * 66'(v_e_reg);
    assign uvv_p = 66'(uv_e_reg) * 66'(v_e_reg);
    assign uuv_p = 66'(uu_e_reg) * 66'(v_e_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_f_reg   <= u_e_reg;
            v_f_reg   <= v_e_reg;
            ok_f_reg  <= ok_e_reg;
            x2_f_reg  <= x2_p[65:30];
            s2_f_reg  <= s2_p[65:30];
            d2_f_reg  <= d2_p[65:30];
            uuu_f_reg <= uuu_p[65:30];
            vvv_f_reg <= vvv_p[65:30];
            uvv_f_reg <= uvv_p[65:30];
            uuv_f_reg <= uuv_p[65:30];
            t1_f_reg  <= term_q32(coef_lin_reg[31:0],  {4'd0, u_e_reg});
            t2_f_reg  <= term_q32(coef_lin_reg[63:32], {4'd0, v_e_reg});
            t3_f_reg  <= term_q32(coef_sq_reg[31:0],   {2'd0, uu_e_reg});
            t4_f_reg  <= term_q32(coef_sq_reg[63:32],  {2'd0, vv_e_reg});
            t5_f_reg  <= term_q32(coef_cc_reg[31:0],   {2'd0, uv_e_reg});
        end
    end

    // ---------------- stage G: region limits, cubic terms ----------------
    logic               inside_g_reg;
    logic signed [45:0] t6_g_reg, t7_g_reg, t8_g_reg, t9_g_reg;
    logic signed [51:0] part_g_reg;
    logic signed [39:0] dmax, dmin, lim_lo, lim_hi, v_s, u_s;

    assign u_s    = $signed({8'd0, u_f_reg});
    assign v_s    = $signed({8'd0, v_f_reg});
    assign dmax   = $signed({4'd0, x2_f_reg}) - $signed({4'd0, d2_f_reg});
    assign dmin   = $signed({4'd0, x2_f_reg}) - $signed({4'd0, s2_f_reg});
    assign lim_lo = $signed({7'd0, SUMSQ}) - u_s - dmax;
    assign lim_hi = $signed({7'd0, SUMSQ}) - u_s - dmin;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // both limits themselves are outside
            inside_g_reg <= ok_f_reg && (v_s > lim_lo) && (v_s < lim_hi);
            t6_g_reg     <= term_q32(coef_cc_reg[63:32], uuu_f_reg);
            t7_g_reg     <= term_q32(coef_cm_reg[31:0],  vvv_f_reg);
            t8_g_reg     <= term_q32(coef_cm_reg[63:32], uvv_f_reg);
            t9_g_reg     <= term_q32(coef_uuv_reg,       uuv_f_reg);
            part_g_reg   <= ONE_Q32 + 52'(t1_f_reg) + 52'(t2_f_reg) + 52'(t3_f_reg)
                            + 52'(t4_f_reg) + 52'(t5_f_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_e_reg <= s3_vld_reg[SQ_STEPS-1];
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
        end
    end

    // ---------------- final sum, saturation, select ----------------
    logic signed [51:0] acc, acc_sat;

    assign acc = part_g_reg + 52'(t6_g_reg) + 52'(t7_g_reg) + 52'(t8_g_reg)
                 + 52'(t9_g_reg);

    always_comb
    begin
        priority if (acc > SAT_HI)
            acc_sat = SAT_HI;
        else if (acc < SAT_LO)
            acc_sat = SAT_LO;
        else
            acc_sat = acc;
    end

    assign res_h.density_value = inside_g_reg ? acc_sat[47:0] : $signed({1'b0, floor_reg});
    assign res_h.inside_region = inside_g_reg;

    // ---------------- two-entry output buffer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= 2'(cnt_reg + 2'(push) - 2'(pop));
    end

    always_ff @(posedge clk)
    begin
        priority if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
            buf0_reg <= res_h;
        else if (pop && cnt_reg == 2'd2)
            buf0_reg <= buf1_reg;
        else
            buf0_reg <= buf0_reg;

        if (push && cnt_reg == 2'd1 && !pop)
            buf1_reg <= res_h;
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result_data  = buf0_reg;

    // ---------------- assertions ----------------
    `DCP_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg != 2'd3, "output buffer count out of range")
    `DCP_ASSERT_NEXT(a_drain, cnt_reg == 2'd2 && !result_stall, cnt_reg == 2'd1, "full buffer did not drain")
    `DCP_ASSERT_NEXT(a_freeze, event_stall, $stable(vld_g_reg) && $stable(s1_vld_reg), "pipeline moved while stalled")

endmodule
